FILE: rtl/core/lcts_pkg.sv
// Package for the tared scale with multiplexed seven-segment display.
// Holds field widths, reset values, register indexes and the decimal and segment helpers.
// Depends on nothing; every other file of the block imports it.
package lcts_pkg;

	localparam int unsigned SAMPLE_SHIFT_DEF = 10;
	localparam int unsigned DIGIT_COUNT_DEF  = 4;

	localparam int unsigned SAMPLE_W    = 24;
	localparam int unsigned READING_W   = 13;
	localparam int unsigned WEIGHT_W    = 14;
	localparam int unsigned GAIN_W      = 4;
	localparam int unsigned THRESH_W    = 16;
	localparam int unsigned SEG_W       = 8;
	localparam int unsigned EN_W        = 4;
	localparam int unsigned DIGIT_W     = 4;
	localparam int unsigned CFG_INDEX_W = 1;
	localparam int unsigned CFG_DATA_W  = 16;

	localparam logic [WEIGHT_W-1:0] WEIGHT_MAX   = 14'd9999;
	localparam logic [GAIN_W-1:0]   GAIN_RESET   = 4'd3;
	localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd499;
	localparam logic [SEG_W-1:0]    SEG_BLANK    = 8'hFF;
	localparam logic [DIGIT_W-1:0]  DIGIT_CLAMP  = 4'hF;

	localparam logic [CFG_INDEX_W-1:0] REG_SCALE_GAIN         = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_INTERVAL_THRESHOLD = 1'd1;

	typedef struct packed {
		logic                updated;
		logic [WEIGHT_W-1:0] weight;
		logic                tared;
	} upd_t;

	// Quotient of v by ten to the power p, through reciprocal multiplication.
	// The constants are exact for every 14-bit value.
	function automatic logic [WEIGHT_W-1:0] div_pow10(input logic [WEIGHT_W-1:0] v,
		input int unsigned p);
		logic [31:0] prod;
		logic [WEIGHT_W-1:0] q;
		prod = '0;
		q = '0;
		case (p)
			0: q = v;
			1: begin
				prod = 32'(v) * 32'd52429;
				q = WEIGHT_W'(prod >> 19);
			end
			2: begin
				prod = 32'(v) * 32'd5243;
				q = WEIGHT_W'(prod >> 19);
			end
			3: begin
				prod = 32'(v) * 32'd8389;
				q = WEIGHT_W'(prod >> 23);
			end
			4: q = (v >= 14'd10000) ? 14'd1 : 14'd0;
			default: q = '0;
		endcase
		return q;
	endfunction

	// Common-anode pattern dp-g-f-e-d-c-b-a, active low.
	function automatic logic [SEG_W-1:0] seg_code(input logic [DIGIT_W-1:0] d);
		logic [SEG_W-1:0] s;
		case (d)
			4'd0: s = 8'hC0;
			4'd1: s = 8'hF9;
			4'd2: s = 8'hA4;
			4'd3: s = 8'hB0;
			4'd4: s = 8'h99;
			4'd5: s = 8'h92;
			4'd6: s = 8'h83;
			4'd7: s = 8'hF8;
			4'd8: s = 8'h80;
			4'd9: s = 8'h98;
			default: s = SEG_BLANK;
		endcase
		return s;
	endfunction

endpackage

FILE: rtl/core/lcts_in_if.sv
// Input channel of the scale: one transaction per millisecond tick.
// Carries the converter ready flag and sample; depends on lcts_pkg.
interface lcts_in_if;
	import lcts_pkg::*;

	logic                valid;
	logic                ready;
	logic                adc_ready;
	logic [SAMPLE_W-1:0] adc_sample;

	modport source (output valid, adc_ready, adc_sample, input ready);
	modport sink (input valid, adc_ready, adc_sample, output ready);
endinterface

FILE: rtl/core/lcts_out_if.sv
// Output channel of the scale: one transaction per accepted tick.
// Carries the display drive and the weight status; depends on lcts_pkg.
interface lcts_out_if;
	import lcts_pkg::*;

	logic                valid;
	logic                ready;
	logic [SEG_W-1:0]    segments_n;
	logic [EN_W-1:0]     digit_enable_n;
	logic [WEIGHT_W-1:0] weight;
	logic                weight_updated;
	logic                tared;

	modport source (output valid, segments_n, digit_enable_n, weight, weight_updated, tared,
		input ready);
	modport sink (input valid, segments_n, digit_enable_n, weight, weight_updated, tared,
		output ready);
endinterface

FILE: rtl/core/load_cell_tare_scale_display.sv
// Tared load-cell scale with a multiplexed seven-segment display, top level.
// An accepted input transaction is registered in the update stage, then in the display output register.
// Throughput: one input transaction per cycle while display_out is ready, set by the two-stage register pipeline.
// Reset (arst_n low, asynchronous): pipeline empty, gain 3, threshold 499, read phase,
// tare and counter cleared, digit store 4,3,2,1 units first, scan at the units digit.
module load_cell_tare_scale_display #(
	parameter int unsigned SAMPLE_SHIFT = lcts_pkg::SAMPLE_SHIFT_DEF,
	parameter int unsigned DIGIT_COUNT  = lcts_pkg::DIGIT_COUNT_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write_en,
	input  logic [lcts_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [lcts_pkg::CFG_DATA_W-1:0]  cfg_data,
	lcts_in_if.sink                          sample_in,
	lcts_out_if.source                       display_out
);
	import lcts_pkg::*;

	logic valid_s1;
	upd_t upd_s1;
	logic s1_taken;

	lcts_update #(
		.SAMPLE_SHIFT(SAMPLE_SHIFT)
	) u_update (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write_en(cfg_write_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.sample_in   (sample_in),
		.s1_taken    (s1_taken),
		.valid_s1    (valid_s1),
		.upd_s1      (upd_s1)
	);

	lcts_display #(
		.DIGIT_COUNT(DIGIT_COUNT)
	) u_display (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_s1   (valid_s1),
		.upd_s1     (upd_s1),
		.s1_taken   (s1_taken),
		.display_out(display_out)
	);

endmodule

FILE: rtl/core/lcts_update.sv
// First stage of the scale: configuration registers, tick counter, sample hold,
// tare and gain arithmetic. Depends on lcts_pkg and lcts_in_if.
module lcts_update #(
	parameter int unsigned SAMPLE_SHIFT = lcts_pkg::SAMPLE_SHIFT_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write_en,
	input  logic [lcts_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [lcts_pkg::CFG_DATA_W-1:0]   cfg_data,
	lcts_in_if.sink                           sample_in,
	input  logic                              s1_taken,
	output logic                              valid_s1,
	output lcts_pkg::upd_t                    upd_s1
);
	import lcts_pkg::*;

	logic [GAIN_W-1:0]    gain_q;
	logic [THRESH_W-1:0]  thresh_q;
	logic [THRESH_W-1:0]  tick_q;
	logic                 wait_q;
	logic [READING_W-1:0] held_q;
	logic [READING_W-1:0] tare_q;
	logic [WEIGHT_W-1:0]  shown_q;

	logic                 accept;
	logic [THRESH_W-1:0]  tick_inc;
	logic                 do_update;
	logic [READING_W-1:0] diff;
	logic [16:0]          product;
	logic [WEIGHT_W-1:0]  scaled;
	logic [WEIGHT_W-1:0]  new_weight;

	assign sample_in.ready = !valid_s1 || s1_taken;

	always_comb begin
		accept = sample_in.valid && sample_in.ready;
		tick_inc = tick_q + 16'd1;
		do_update = wait_q && (tick_inc > thresh_q);
		diff = (held_q >= tare_q) ? (held_q - tare_q) : '0;
		product = {4'b0, diff} * {13'b0, gain_q};
		scaled = (product > 17'(WEIGHT_MAX)) ? WEIGHT_MAX : product[WEIGHT_W-1:0];
		new_weight = (tare_q != '0) ? scaled : {1'b0, held_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q   <= GAIN_RESET;
			thresh_q <= THRESH_RESET;
			tick_q   <= '0;
			wait_q   <= 1'b0;
			held_q   <= '0;
			tare_q   <= '0;
			shown_q  <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (cfg_write_en) begin
				case (cfg_index)
					REG_SCALE_GAIN:         gain_q <= cfg_data[GAIN_W-1:0];
					REG_INTERVAL_THRESHOLD: thresh_q <= cfg_data[THRESH_W-1:0];
					default: ;
				endcase
			end
			if (accept) begin
				valid_s1 <= 1'b1;
				tick_q <= do_update ? '0 : tick_inc;
				if (!wait_q && sample_in.adc_ready) begin
					held_q <= sample_in.adc_sample[SAMPLE_SHIFT +: READING_W];
					wait_q <= 1'b1;
				end
				if (do_update) begin
					wait_q <= 1'b0;
					shown_q <= new_weight;
					if (tare_q == '0) begin
						tare_q <= held_q;
					end
				end
			end else if (s1_taken) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			upd_s1.updated <= do_update;
			upd_s1.weight  <= do_update ? new_weight : shown_q;
			upd_s1.tared   <= (tare_q != '0) || (do_update && held_q != '0);
		end
	end

	// Once a tare is stored it never changes.
	assert property (@(posedge clk) disable iff (!arst_n)
		(tare_q != '0) |=> (tare_q == $past(tare_q)))
		else $error("tare value changed after it was stored");

	// While the stage holds an updating transaction, the block is back in the read phase.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && upd_s1.updated) |-> !wait_q)
		else $error("wait phase still set after an update");

endmodule

FILE: rtl/core/lcts_display.sv
// Second stage of the scale: decimal digit store, scan position and segment decode,
// feeding the output register. Depends on lcts_pkg and lcts_out_if.
module lcts_display #(
	parameter int unsigned DIGIT_COUNT = lcts_pkg::DIGIT_COUNT_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           valid_s1,
	input  lcts_pkg::upd_t upd_s1,
	output logic           s1_taken,
	lcts_out_if.source     display_out
);
	import lcts_pkg::*;

	localparam int unsigned IDX_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DIGIT_COUNT - 1);

	logic [DIGIT_W-1:0]  digits_q [DIGIT_COUNT];
	logic [IDX_W-1:0]    scan_q;
	logic                valid_s2;
	logic [SEG_W-1:0]    segments_n_s2;
	logic [EN_W-1:0]     digit_enable_n_s2;
	logic [WEIGHT_W-1:0] weight_s2;
	logic                weight_updated_s2;
	logic                tared_s2;

	logic [WEIGHT_W-1:0] quot [DIGIT_COUNT];
	logic [DIGIT_W-1:0]  split [DIGIT_COUNT];
	logic [WEIGHT_W-1:0] rem_w;
	logic [EN_W-1:0]     en_n;

	assign s1_taken = valid_s1 && (!valid_s2 || display_out.ready);

	always_comb begin
		rem_w = '0;
		for (int i = 0; i < DIGIT_COUNT; i++) begin
			quot[i] = div_pow10(upd_s1.weight, i);
		end
		for (int i = 0; i < DIGIT_COUNT; i++) begin
			if (i == DIGIT_COUNT - 1) begin
				split[i] = (quot[i] > WEIGHT_W'(DIGIT_CLAMP)) ? DIGIT_CLAMP
					: quot[i][DIGIT_W-1:0];
			end else begin
				rem_w = quot[i] - ((quot[i+1] << 3) + (quot[i+1] << 1));
				split[i] = rem_w[DIGIT_W-1:0];
			end
		end
		for (int j = 0; j < EN_W; j++) begin
			en_n[j] = (int'(scan_q) != j);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIGIT_COUNT; i++) begin
				digits_q[i] <= DIGIT_W'(DIGIT_COUNT - i);
			end
			scan_q   <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (s1_taken) begin
				valid_s2 <= 1'b1;
				scan_q <= (scan_q == IDX_LAST) ? '0 : scan_q + 1'b1;
				if (upd_s1.updated) begin
					for (int i = 0; i < DIGIT_COUNT; i++) begin
						digits_q[i] <= split[i];
					end
				end
			end else if (display_out.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// The lit digit is taken from the store as it stood before this transaction's update.
	always_ff @(posedge clk) begin
		if (s1_taken) begin
			segments_n_s2     <= seg_code(digits_q[scan_q]);
			digit_enable_n_s2 <= en_n;
			weight_s2         <= upd_s1.weight;
			weight_updated_s2 <= upd_s1.updated;
			tared_s2          <= upd_s1.tared;
		end
	end

	assign display_out.valid          = valid_s2;
	assign display_out.segments_n     = segments_n_s2;
	assign display_out.digit_enable_n = digit_enable_n_s2;
	assign display_out.weight         = weight_s2;
	assign display_out.weight_updated = weight_updated_s2;
	assign display_out.tared          = tared_s2;

	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> ($countones(~digit_enable_n_s2) <= 1))
		else $error("more than one digit enabled");

	assert property (@(posedge clk) disable iff (!arst_n)
		int'(scan_q) < DIGIT_COUNT)
		else $error("scan position beyond the digit count");

	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (weight_s2 <= WEIGHT_MAX))
		else $error("weight above the display limit");

endmodule

FILE: sim/load_cell_tare_scale_display_tb.sv
// Self-checking testbench for the tared load-cell scale with multiplexed display.
// Drives tick transactions, predicts every display transaction and compares field by field.
// Depends on lcts_pkg, lcts_in_if, lcts_out_if and the load_cell_tare_scale_display RTL.
module load_cell_tare_scale_display_tb;
	import lcts_pkg::*;

	localparam int IDLE_LIMIT = 2000;
	localparam int TICK_TARGET = 850;

	typedef struct packed {
		logic                rdy;
		logic [SAMPLE_W-1:0] smp;
	} tick_t;

	typedef struct packed {
		logic [SEG_W-1:0]    seg;
		logic [EN_W-1:0]     en;
		logic [WEIGHT_W-1:0] weight;
		logic                updated;
		logic                tared;
	} display_t;

	typedef enum logic [1:0] {RX_FREE, RX_RANDOM, RX_PATTERN, RX_SPARSE} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write_en = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = REG_SCALE_GAIN;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	logic drv_valid = 1'b0;
	logic drv_adc_ready = 1'b0;
	logic [SAMPLE_W-1:0] drv_sample = '0;
	logic mon_ready = 1'b0;

	tick_t tick_queue[$];
	display_t expected_display[$];
	int ticks_queued = 0;
	int fail_count = 0;
	int burst_left = 1;
	int gap_left = 0;
	int idle_cycles = 0;

	rx_mode_t recv_mode = RX_FREE;
	int mode_left = 0;
	logic [7:0] recv_pattern = 8'hFF;
	logic [2:0] pattern_pos = '0;

	logic [GAIN_W-1:0] gain_reg = GAIN_RESET;
	logic [THRESH_W-1:0] thresh_reg = THRESH_RESET;
	logic [1:0] scan_pos = '0;
	logic [DIGIT_W-1:0] digit_store [4];
	logic awaiting_update = 1'b0;
	logic [SAMPLE_W-1:0] latched_sample = '0;
	logic [READING_W-1:0] tare_reading = '0;
	logic [THRESH_W-1:0] ms_count = '0;
	logic [WEIGHT_W-1:0] shown_weight = '0;

	lcts_in_if sample_in();
	lcts_out_if display_out();

	assign sample_in.valid = drv_valid;
	assign sample_in.adc_ready = drv_adc_ready;
	assign sample_in.adc_sample = drv_sample;
	assign display_out.ready = mon_ready;

	load_cell_tare_scale_display u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write_en(cfg_write_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.sample_in(sample_in),
		.display_out(display_out)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [SEG_W-1:0] segment_pattern(input logic [DIGIT_W-1:0] d);
		logic [SEG_W-1:0] s;
		case (d)
			4'd0: s = 8'hC0;
			4'd1: s = 8'hF9;
			4'd2: s = 8'hA4;
			4'd3: s = 8'hB0;
			4'd4: s = 8'h99;
			4'd5: s = 8'h92;
			4'd6: s = 8'h83;
			4'd7: s = 8'hF8;
			4'd8: s = 8'h80;
			4'd9: s = 8'h98;
			default: s = SEG_BLANK;
		endcase
		return s;
	endfunction

	// Advances the scale by one tick and returns the display drive that tick produces.
	function automatic display_t weigh_tick(input logic rdy, input logic [SAMPLE_W-1:0] smp);
		display_t res;
		logic [1:0] pos;
		logic [READING_W-1:0] reading;
		int unsigned val;
		pos = scan_pos;
		res.seg = segment_pattern(digit_store[pos]);
		res.en = ~(EN_W'(1) << pos);
		res.updated = 1'b0;
		scan_pos = pos + 2'd1;
		ms_count = ms_count + 16'd1;
		if (!awaiting_update) begin
			if (rdy) begin
				latched_sample = smp;
				awaiting_update = 1'b1;
			end
		end else if (ms_count > thresh_reg) begin
			reading = latched_sample[SAMPLE_SHIFT_DEF +: READING_W];
			ms_count = '0;
			if (tare_reading != '0) begin
				val = (reading >= tare_reading) ? 32'(reading) - 32'(tare_reading) : 0;
				val = val * 32'(gain_reg);
				if (val > 32'(WEIGHT_MAX))
					val = 32'(WEIGHT_MAX);
			end else begin
				tare_reading = reading;
				val = 32'(reading);
			end
			shown_weight = WEIGHT_W'(val);
			digit_store[0] = DIGIT_W'(val % 10);
			digit_store[1] = DIGIT_W'((val / 10) % 10);
			digit_store[2] = DIGIT_W'((val / 100) % 10);
			digit_store[3] = DIGIT_W'(val / 1000);
			awaiting_update = 1'b0;
			res.updated = 1'b1;
		end
		res.weight = shown_weight;
		res.tared = (tare_reading != '0);
		return res;
	endfunction

	// Mostly readings close to the tare so that weights stay in range, sometimes anything.
	function automatic logic [SAMPLE_W-1:0] sample_near_tare();
		int reading;
		if ($urandom_range(0, 3) == 0)
			return SAMPLE_W'($urandom);
		reading = int'(tare_reading) - 30 + int'($urandom_range(0, 730));
		if (reading < 0)
			reading = 0;
		if (reading > 8191)
			reading = 8191;
		return {1'($urandom), READING_W'(reading), SAMPLE_SHIFT_DEF'($urandom)};
	endfunction

	task automatic push_tick(input logic rdy, input logic [SAMPLE_W-1:0] smp);
		tick_queue.push_back('{rdy: rdy, smp: smp});
		ticks_queued++;
	endtask

	task automatic push_reading(input int reading, input logic [SAMPLE_W-1:0] low_bits);
		push_tick(1'b1, (SAMPLE_W'(reading) << SAMPLE_SHIFT_DEF) | low_bits);
		push_tick(1'b0, '0);
	endtask

	task automatic queue_phase(input int n, input int thresh);
		int i;
		int k;
		int j;
		i = 0;
		while (i < n) begin
			if (thresh < 100 && $urandom_range(0, 9) < 7) begin
				push_tick(1'b1, sample_near_tare());
				k = $urandom_range(0, thresh + 2);
				for (j = 0; j < k; j++)
					push_tick(1'($urandom), sample_near_tare());
				i += k + 1;
			end else begin
				push_tick(1'($urandom), SAMPLE_W'($urandom));
				i++;
			end
		end
	endtask

	task automatic drain();
		do
			@(negedge clk);
		while (tick_queue.size() != 0 || drv_valid || expected_display.size() != 0);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_write_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		if (idx == REG_SCALE_GAIN)
			gain_reg = data[GAIN_W-1:0];
		else
			thresh_reg = data[THRESH_W-1:0];
	endtask

	task automatic compare_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin : driver
		tick_t next_tick;
		if (arst_n) begin
			if (drv_valid && sample_in.ready)
				expected_display.push_back(weigh_tick(drv_adc_ready, drv_sample));
			if (!drv_valid || sample_in.ready) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					drv_valid <= 1'b0;
				end else if (tick_queue.size() == 0) begin
					drv_valid <= 1'b0;
				end else begin
					next_tick = tick_queue.pop_front();
					drv_valid <= 1'b1;
					drv_adc_ready <= next_tick.rdy;
					drv_sample <= next_tick.smp;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 24);
						gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					end else begin
						burst_left <= burst_left - 1;
					end
				end
			end
		end
	end

	always @(posedge clk) begin : monitor
		display_t want;
		if (arst_n) begin
			if (display_out.valid && mon_ready) begin
				if (expected_display.size() == 0) begin
					$display("%0t: display transaction with none expected", $time);
					fail_count++;
				end else begin
					want = expected_display.pop_front();
					compare_field("segments_n", want.seg, display_out.segments_n);
					compare_field("digit_enable_n", want.en, display_out.digit_enable_n);
					compare_field("weight", want.weight, display_out.weight);
					compare_field("weight_updated", want.updated, display_out.weight_updated);
					compare_field("tared", want.tared, display_out.tared);
				end
			end
			if (mode_left == 0) begin
				recv_mode <= rx_mode_t'($urandom_range(0, 3));
				mode_left <= $urandom_range(20, 80);
				recv_pattern <= 8'($urandom) | 8'h01;
			end else begin
				mode_left <= mode_left - 1;
			end
			pattern_pos <= pattern_pos + 3'd1;
			case (recv_mode)
				RX_FREE: mon_ready <= 1'b1;
				RX_RANDOM: mon_ready <= ($urandom_range(0, 2) != 0);
				RX_PATTERN: mon_ready <= recv_pattern[pattern_pos];
				default: mon_ready <= ($urandom_range(0, 4) == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((drv_valid && sample_in.ready) || (display_out.valid && mon_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles == IDLE_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int phase_num;
		int n;
		int t;
		logic [GAIN_W-1:0] g;
		digit_store[0] = 4'd4;
		digit_store[1] = 4'd3;
		digit_store[2] = 4'd2;
		digit_store[3] = 4'd1;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: the scan walks the power-on digits and a zero reading is held.
		push_tick(1'b1, 24'h8003FF);
		push_tick(1'b0, 24'hFFFFFF);
		push_tick(1'b1, 24'h7FFFFF);
		push_tick(1'b0, '0);
		drain();
		write_reg(REG_SCALE_GAIN, {12'($urandom), 4'd15});
		write_reg(REG_INTERVAL_THRESHOLD, 16'd0);
		@(negedge clk);

		// With a zero threshold the held zero reading is shown without taring.
		push_tick(1'b0, '0);
		push_tick(1'b0, 24'hFFFFFF);
		push_reading(5, 24'h0002AA);
		push_reading(3, '0);
		push_reading(8191, '0);
		push_reading(5 + 666, 24'h0003FF);
		push_reading(5 + 123, 24'h0003FF);
		push_reading(5 + 456, '0);
		push_reading(5 + 159, 24'h000155);
		push_reading(5 + 518, '0);
		push_reading(5, '0);

		phase_num = 0;
		while (ticks_queued < TICK_TARGET) begin
			drain();
			case (phase_num)
				0: begin
					g = 4'd0;
					t = 1;
					n = 60;
				end
				1: begin
					g = 4'd15;
					t = 65535;
					n = 50;
				end
				2: begin
					g = 4'd1;
					t = 40;
					n = 120;
				end
				default: begin
					g = GAIN_W'($urandom);
					t = $urandom_range(0, 6);
					n = $urandom_range(40, 90);
				end
			endcase
			write_reg(REG_SCALE_GAIN, {12'($urandom), g});
			write_reg(REG_INTERVAL_THRESHOLD, THRESH_W'(t));
			@(negedge clk);
			queue_phase(n, t);
			phase_num++;
		end

		drain();
		repeat (4) @(negedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule

FILE: filelist.f
rtl/core/lcts_pkg.sv
rtl/core/lcts_in_if.sv
rtl/core/lcts_out_if.sv
rtl/core/lcts_update.sv
rtl/core/lcts_display.sv
rtl/core/load_cell_tare_scale_display.sv
sim/load_cell_tare_scale_display_tb.sv
